[hw/rtl/nibble_frame_deframer_assert.svh]
// assertion macros used by the deframer checker
`ifndef NIBBLE_FRAME_DEFRAMER_ASSERT_SVH
`define NIBBLE_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nfd check failed");

// next-cycle implication, checked outside reset
`define NFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nfd check failed");

`endif

[hw/rtl/nfd_pkg.sv]
// types and constants of the nibble frame deframer
package nfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned RAW_CNT_W = 12;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] START_FLAG_RST = 8'h2A;
  localparam logic [BYTE_W-1:0] END_FLAG_RST   = 8'h3B;

  localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG   = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BADLEN   = 3'd2,
    KIND_ABANDON  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_e;

endpackage

[hw/rtl/nfd_if.sv]
// valid/ready channels for raw bytes in and decoded results out
interface nfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [nfd_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [nfd_pkg::KIND_W-1:0]  kind;
  logic [nfd_pkg::BYTE_W-1:0]  data_byte;
  logic [nfd_pkg::LEN_W-1:0]   dec_len;
  logic [nfd_pkg::CNT_W-1:0]   error_count;
  logic [nfd_pkg::CNT_W-1:0]   good_count;

  modport source (output valid, output kind, output data_byte, output dec_len,
                  output error_count, output good_count, input ready);
  modport sink   (input valid, input kind, input data_byte, input dec_len,
                  input error_count, input good_count, output ready);
endinterface

[hw/rtl/nibble_frame_deframer.sv]
// Start/end delimited nibble-split deframer.
// in_ch carries one raw link byte per item. Outside a frame the block hunts
// for the start flag; inside, byte pairs merge their low nibbles into one
// decoded byte, sent on out_ch as a data item. The end flag closes the frame
// with a good or bad-length item; a start flag inside a frame abandons it,
// and a frame longer than MAX_RAW_LEN raw bytes is dropped as overflow.
// Each result carries the running error and good byte counters.
// A raw byte is captured in the input register, decoded from there, and its
// result (if any) is written into the result register that drives out_ch.
// Throughput: one raw byte per cycle while results are taken; the decode is
// a flag compare, a nibble merge and one 32-bit counter add between the
// input and result registers. If out_ch stalls, the result register holds and
// the input register fills, after which in_ch.ready drops until the result
// is taken.
// Reset clears the frame state, both counters and the pipeline; the flags
// return to 0x2A (start) and 0x3B (end). cfg writes belong where no item is in flight.
module nibble_frame_deframer #(
  parameter int unsigned MAX_RAW_LEN = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nfd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [nfd_pkg::BYTE_W-1:0]      cfg_data_i,
  nfd_in_if.sink                          in_ch,
  nfd_out_if.source                       out_ch
);

  localparam logic [nfd_pkg::RAW_CNT_W-1:0] MaxRawLen = nfd_pkg::RAW_CNT_W'(MAX_RAW_LEN);

  logic [nfd_pkg::BYTE_W-1:0]    start_flag_q, end_flag_q;

  logic                          in_vld_q;
  logic [nfd_pkg::BYTE_W-1:0]    in_byte_q;

  logic                          in_frame_q, in_frame_d;
  logic                          phase_q, phase_d;
  logic [nfd_pkg::NIBBLE_W-1:0]  held_q, held_d;
  logic [nfd_pkg::RAW_CNT_W-1:0] raw_q, raw_d;
  logic [nfd_pkg::CNT_W-1:0]     err_q, err_d;
  logic [nfd_pkg::CNT_W-1:0]     good_q, good_d;

  logic                          res_vld;
  nfd_pkg::kind_e                res_kind;
  logic [nfd_pkg::BYTE_W-1:0]    res_data;
  logic [nfd_pkg::LEN_W-1:0]     res_len;

  logic                          out_vld_q;
  nfd_pkg::kind_e                out_kind_q;
  logic [nfd_pkg::BYTE_W-1:0]    out_data_q;
  logic [nfd_pkg::LEN_W-1:0]     out_len_q;
  logic [nfd_pkg::CNT_W-1:0]     out_err_q, out_good_q;

  logic                          advance;

  assign advance     = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_flag_q <= nfd_pkg::START_FLAG_RST;
      end_flag_q   <= nfd_pkg::END_FLAG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nfd_pkg::CFG_START_FLAG: start_flag_q <= cfg_data_i;
        nfd_pkg::CFG_END_FLAG:   end_flag_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_q <= in_ch.rx_byte;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    phase_d    = phase_q;
    held_d     = held_q;
    raw_d      = raw_q;
    err_d      = err_q;
    good_d     = good_q;
    res_vld    = 1'b0;
    res_kind   = nfd_pkg::KIND_DATA;
    res_data   = '0;
    res_len    = raw_q[nfd_pkg::RAW_CNT_W-1:1];

    if (!in_frame_q) begin
      if (in_byte_q == start_flag_q) begin
        in_frame_d = 1'b1;
        phase_d    = 1'b0;
        held_d     = '0;
        raw_d      = '0;
      end else begin
        err_d = err_q + nfd_pkg::CNT_W'(1);
      end
    end else if (in_byte_q == end_flag_q) begin
      res_vld = 1'b1;
      if (raw_q != '0 && !raw_q[0]) begin
        good_d   = good_q + nfd_pkg::CNT_W'(raw_q) + nfd_pkg::CNT_W'(2);
        res_kind = nfd_pkg::KIND_GOOD;
      end else begin
        res_kind = nfd_pkg::KIND_BADLEN;
      end
      in_frame_d = 1'b0;
      phase_d    = 1'b0;
      held_d     = '0;
      raw_d      = '0;
    end else if (in_byte_q == start_flag_q) begin
      // old frame's start flag and bytes are discarded, new frame opens here
      res_vld    = 1'b1;
      res_kind   = nfd_pkg::KIND_ABANDON;
      err_d      = err_q + nfd_pkg::CNT_W'(raw_q) + nfd_pkg::CNT_W'(1);
      in_frame_d = 1'b1;
      phase_d    = 1'b0;
      held_d     = '0;
      raw_d      = '0;
    end else if (raw_q >= MaxRawLen) begin
      res_vld    = 1'b1;
      res_kind   = nfd_pkg::KIND_OVERFLOW;
      err_d      = err_q + nfd_pkg::CNT_W'(raw_q) + nfd_pkg::CNT_W'(2);
      in_frame_d = 1'b0;
      phase_d    = 1'b0;
      held_d     = '0;
      raw_d      = '0;
    end else begin
      raw_d = raw_q + nfd_pkg::RAW_CNT_W'(1);
      if (!phase_q) begin
        held_d  = in_byte_q[nfd_pkg::NIBBLE_W-1:0];
        phase_d = 1'b1;
      end else begin
        phase_d  = 1'b0;
        res_vld  = 1'b1;
        res_data = {held_q, in_byte_q[nfd_pkg::NIBBLE_W-1:0]};
        res_len  = raw_d[nfd_pkg::RAW_CNT_W-1:1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      phase_q    <= 1'b0;
      held_q     <= '0;
      raw_q      <= '0;
      err_q      <= '0;
      good_q     <= '0;
    end else if (advance) begin
      in_frame_q <= in_frame_d;
      phase_q    <= phase_d;
      held_q     <= held_d;
      raw_q      <= raw_d;
      err_q      <= err_d;
      good_q     <= good_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_vld;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_kind_q <= res_kind;
      out_data_q <= res_data;
      out_len_q  <= res_len;
      out_err_q  <= err_d;
      out_good_q <= good_d;
    end
  end

  assign out_ch.valid       = out_vld_q;
  assign out_ch.kind        = out_kind_q;
  assign out_ch.data_byte   = out_data_q;
  assign out_ch.dec_len     = out_len_q;
  assign out_ch.error_count = out_err_q;
  assign out_ch.good_count  = out_good_q;

endmodule

[hw/rtl/nfd_checker.sv]
// port-level checks of the deframer, bound to the top level
`include "nibble_frame_deframer_assert.svh"

module nfd_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [nfd_pkg::KIND_W-1:0]     out_kind_i,
  input  logic [nfd_pkg::BYTE_W-1:0]     out_data_i,
  input  logic [nfd_pkg::LEN_W-1:0]      out_len_i
);

  logic kind_data, kind_good;

  assign kind_data = out_kind_i == nfd_pkg::KIND_DATA;
  assign kind_good = out_kind_i == nfd_pkg::KIND_GOOD;

  // a pending result is never withdrawn
  `NFD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // with the result register empty the input side is never stalled
  `NFD_ASSERT_NOW(a_in_free, !out_valid_i && in_valid_i, in_ready_i)
  // only data items carry a decoded byte
  `NFD_ASSERT_NOW(a_data_zero, out_valid_i && !kind_data, out_data_i == '0)
  // data items and good ends always follow at least one decoded byte
  `NFD_ASSERT_NOW(a_len_nonzero, out_valid_i && (kind_data || kind_good), out_len_i != '0)

endmodule

bind nibble_frame_deframer nfd_checker u_nfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_kind_i  (out_ch.kind),
  .out_data_i  (out_ch.data_byte),
  .out_len_i   (out_ch.dec_len)
);
